// ===== sv/ugnp_pkg.sv =====
package ugnp_pkg;

  localparam int unsigned ValW   = 32;  // level-set values and speed
  localparam int unsigned PosW   = 31;  // spacings, radius, angle step, result
  localparam int unsigned FracW  = 16;
  localparam int unsigned DivLat = 32;  // precompute stage + one stage per quotient bit
  localparam int unsigned SqrtLat = 32; // one stage per root bit
  localparam int unsigned PipeLat = 1 + 2 * DivLat + 2 + SqrtLat;

  localparam logic [PosW-1:0] OutMax = {PosW{1'b1}};

  // configuration register indexes
  localparam logic CfgDirection = 1'b0;
  localparam logic CfgAngleStep = 1'b1;

  localparam logic [1:0] DirReset   = 2'b01;
  localparam logic [PosW-1:0] AngleReset = 31'd411775;

  // numerators and divisors handed from the front stage to the dividers
  typedef struct packed {
    logic [ValW-1:0] num_outer;
    logic [ValW-1:0] num_inner;
    logic [ValW-1:0] num_ang;
    logic [PosW-1:0] sp_outer;
    logic [PosW-1:0] sp_inner;
    logic [PosW-1:0] ang_step;
    logic [PosW-1:0] radius;
  } front_t;

endpackage

// ===== sv/upwind_gradient_norm_polar.sv =====
// Upwind gradient magnitude for one node of a polar level-set grid, Q16.16.
// Streams one node per cycle: a node is taken on every cycle in which
// in_valid_i and in_ready_o are both high, and its grad_norm_o passes
// through the front stage, two 32-stage division levels in series,
// a squaring stage, a sum stage, a 32-stage square root and the output register.
// The whole pipeline advances together; an output register plus one skid
// entry let a new node be accepted while a finished result waits, and
// in_ready_o drops only once the skid entry is occupied. Configuration
// (direction_sign at index 0, angle_step at index 1) is written through
// cfg_we_i and must only change while no node is in flight.
module upwind_gradient_norm_polar (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [ugnp_pkg::PosW-1:0]        cfg_data_i,
  // node input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [ugnp_pkg::ValW-1:0] center_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] outer_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] inner_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] ahead_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] behind_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] speed_i,
  input  logic [ugnp_pkg::PosW-1:0]        outer_spacing_i,
  input  logic [ugnp_pkg::PosW-1:0]        inner_spacing_i,
  input  logic [ugnp_pkg::PosW-1:0]        radius_i,
  // result
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ugnp_pkg::PosW-1:0]        grad_norm_o
);

  localparam int unsigned PW = ugnp_pkg::PosW;
  localparam int unsigned DL = ugnp_pkg::DivLat;
  localparam int unsigned PL = ugnp_pkg::PipeLat;

  // configuration registers
  logic signed [1:0] dir_q;
  logic [PW-1:0]     angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= ugnp_pkg::DirReset;
      angle_q <= ugnp_pkg::AngleReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ugnp_pkg::CfgDirection) begin
        dir_q <= cfg_data_i[1:0];
      end else begin
        angle_q <= cfg_data_i;
      end
    end
  end

  // global advance: the pipeline moves whenever the skid entry is free
  logic adv;
  logic skid_v_q, out_v_q;
  logic [PW-1:0] skid_d_q, out_d_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  // valid bits, one per pipeline register
  logic [PL-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[PL-2:0], in_valid_i};
    end
  end

  // stage 1: upwind branch and numerators
  ugnp_pkg::front_t front;

  ugnp_front u_front (
    .clk_i,
    .en_i           (adv),
    .center_value_i,
    .outer_value_i,
    .inner_value_i,
    .ahead_value_i,
    .behind_value_i,
    .speed_i,
    .outer_spacing_i,
    .inner_spacing_i,
    .radius_i,
    .dir_i          (dir_q),
    .angle_step_i   (angle_q),
    .front_o        (front)
  );

  // first division level: both radial quotients and the angular quotient
  logic [PW-1:0] q_outer, q_inner, q_ang, q_tan;

  ugnp_div u_div_outer (
    .clk_i, .en_i(adv), .num_i(front.num_outer), .den_i(front.sp_outer), .quot_o(q_outer)
  );
  ugnp_div u_div_inner (
    .clk_i, .en_i(adv), .num_i(front.num_inner), .den_i(front.sp_inner), .quot_o(q_inner)
  );
  ugnp_div u_div_ang (
    .clk_i, .en_i(adv), .num_i(front.num_ang), .den_i(front.ang_step), .quot_o(q_ang)
  );

  // radius rides alongside the first divider level, radial term along the second
  logic [PW-1:0] r_dly_q   [0:DL-1];
  logic [PW-1:0] rad_dly_q [0:DL-1];
  logic [PW-1:0] rad;

  assign rad = (q_outer > q_inner) ? q_outer : q_inner;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_dly_q[0]   <= front.radius;
      rad_dly_q[0] <= rad;
      for (int k = 1; k < DL; k++) begin
        r_dly_q[k]   <= r_dly_q[k-1];
        rad_dly_q[k] <= rad_dly_q[k-1];
      end
    end
  end

  // second division level: angular quotient over radius
  ugnp_div u_div_tan (
    .clk_i, .en_i(adv), .num_i({1'b0, q_ang}), .den_i(r_dly_q[DL-1]), .quot_o(q_tan)
  );

  // squares, then their exact sum at 32 fraction bits
  logic [2*PW-1:0] rsq_q, tsq_q;
  logic [2*PW:0]   sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsq_q <= rad_dly_q[DL-1] * rad_dly_q[DL-1];
      tsq_q <= q_tan * q_tan;
      sum_q <= {1'b0, rsq_q} + {1'b0, tsq_q};
    end
  end

  logic [PW-1:0] root;

  ugnp_sqrt u_sqrt (
    .clk_i, .en_i(adv), .x_i({1'b0, sum_q}), .root_o(root)
  );

  // output register with one skid entry
  logic last_v;
  assign last_v = v_q[PL-1] && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q || last_v;
      skid_v_q <= 1'b0;
    end else if (last_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_d_q <= skid_v_q ? skid_d_q : root;
    end else if (last_v) begin
      skid_d_q <= root;
    end
  end

  assign out_valid_o = out_v_q;
  assign grad_norm_o = out_d_q;

endmodule

// ===== sv/ugnp_front.sv =====
module ugnp_front (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ugnp_pkg::ValW-1:0] center_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] outer_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] inner_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] ahead_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] behind_value_i,
  input  logic signed [ugnp_pkg::ValW-1:0] speed_i,
  input  logic [ugnp_pkg::PosW-1:0]    outer_spacing_i,
  input  logic [ugnp_pkg::PosW-1:0]    inner_spacing_i,
  input  logic [ugnp_pkg::PosW-1:0]    radius_i,
  input  logic signed [1:0]            dir_i,
  input  logic [ugnp_pkg::PosW-1:0]    angle_step_i,
  output ugnp_pkg::front_t             front_o
);

  ugnp_pkg::front_t front_d, front_q;
  logic first;
  logic [ugnp_pkg::ValW-1:0] n_ahead, n_behind;

  // positive part of a - b, signed operands
  function automatic logic [ugnp_pkg::ValW-1:0] pos_diff(
    input logic signed [ugnp_pkg::ValW-1:0] a,
    input logic signed [ugnp_pkg::ValW-1:0] b
  );
    logic signed [ugnp_pkg::ValW:0] d;
    d = {a[ugnp_pkg::ValW-1], a} - {b[ugnp_pkg::ValW-1], b};
    return (a > b) ? d[ugnp_pkg::ValW-1:0] : '0;
  endfunction

  always_comb begin
    // zero speed or zero direction falls to the second branch
    first = (!speed_i[ugnp_pkg::ValW-1] && (speed_i != '0) && (dir_i == 2'sb01)) ||
            (speed_i[ugnp_pkg::ValW-1] && dir_i[1]);
    if (first) begin
      front_d.num_outer = pos_diff(outer_value_i, center_value_i);
      front_d.num_inner = pos_diff(inner_value_i, center_value_i);
      n_ahead  = pos_diff(ahead_value_i, center_value_i);
      n_behind = pos_diff(behind_value_i, center_value_i);
    end else begin
      front_d.num_outer = pos_diff(center_value_i, outer_value_i);
      front_d.num_inner = pos_diff(center_value_i, inner_value_i);
      n_ahead  = pos_diff(center_value_i, ahead_value_i);
      n_behind = pos_diff(center_value_i, behind_value_i);
    end
    front_d.num_ang  = (n_ahead > n_behind) ? n_ahead : n_behind;
    front_d.sp_outer = outer_spacing_i;
    front_d.sp_inner = inner_spacing_i;
    front_d.ang_step = angle_step_i;
    front_d.radius   = radius_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== sv/ugnp_div.sv =====
// floor((num << 16) / den), saturated; one quotient bit per stage
module ugnp_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ugnp_pkg::ValW-1:0] num_i,
  input  logic [ugnp_pkg::PosW-1:0] den_i,
  output logic [ugnp_pkg::PosW-1:0] quot_o
);

  localparam int unsigned W = ugnp_pkg::PosW;

  logic [W-1:0] rem_q  [0:W];
  logic [W-1:0] lo_q   [0:W];
  logic [W-1:0] den_q  [0:W];
  logic [W-1:0] quo_q  [0:W];
  logic         sat_q  [0:W];
  logic         zero_q [0:W];

  logic sat_d;

  // quotient overflows 31 bits when num >= den * 2^15
  assign sat_d = (num_i != '0) &&
                 ({14'd0, num_i} >= {den_i, 15'd0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {14'd0, num_i[ugnp_pkg::ValW-1:15]};
      lo_q[0]   <= {num_i[14:0], 16'd0};
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= sat_d;
      zero_q[0] <= (num_i == '0);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W:0] t, diff;
    logic       ge;
    assign t    = {rem_q[k-1], lo_q[k-1][W-1]};
    assign ge   = t >= {1'b0, den_q[k-1]};
    assign diff = t - {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[W-1:0] : t[W-1:0];
        lo_q[k]   <= {lo_q[k-1][W-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][W-2:0], ge};
        sat_q[k]  <= sat_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign quot_o = zero_q[W] ? '0 : (sat_q[W] ? ugnp_pkg::OutMax : quo_q[W]);

endmodule

// ===== sv/ugnp_sqrt.sv =====
// floor square root, one root bit per stage, saturated to 31 bits
module ugnp_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [63:0]               x_i,
  output logic [ugnp_pkg::PosW-1:0] root_o
);

  localparam int unsigned N = ugnp_pkg::SqrtLat;

  logic [33:0] rem_q  [1:N];
  logic [N-1:0] root_q [1:N];
  logic [63:0] xs_q   [1:N];

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [33:0]  rem_p;
    logic [N-1:0] root_p;
    logic [63:0]  xs_p;
    logic [35:0]  t, trial, diff;
    logic         ge;
    if (k == 1) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign xs_p   = x_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign xs_p   = xs_q[k-1];
    end
    assign t     = {rem_p, xs_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[33:0] : t[33:0];
        root_q[k] <= {root_p[N-2:0], ge};
        xs_q[k]   <= {xs_p[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N][N-1] ? ugnp_pkg::OutMax : root_q[N][ugnp_pkg::PosW-1:0];

endmodule

// ===== sv/ugnp_checker.sv =====
module ugnp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [ugnp_pkg::PosW-1:0] grad_norm_o
);

  // input side only backs up behind a waiting result
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // a taken result always frees the input side next cycle
  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("input still stalled after result transfer");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(grad_norm_o)))
    else $error("stalled result changed");

endmodule

bind upwind_gradient_norm_polar ugnp_checker u_ugnp_checker (
  .clk_i,
  .rst_ni,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .grad_norm_o
);
